>>> hdl/til_pkg.sv
// Shared constants, codes and control structures of the timed interval lookup block.
package til_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int TIME_W      = 32;
	localparam int REM_W       = 10;
	localparam int OUT_IDX_W   = 10;
	localparam int KIND_W      = 2;

	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	// Source of the table read address.
	typedef enum logic [1:0] {
		ADDR_PTR,
		ADDR_MID,
		ADDR_FIRST,
		ADDR_LAST
	} til_addr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic          load;
		logic          clear;
		logic          cap_query;
		logic          rd_en;
		til_addr_sel_t rd_sel;
		logic          ptr_inc;
		logic          bs_step;
		logic          res_write;
		logic          res_found;
		logic          rem_zero;
	} til_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cnt_zero;
		logic ptr_in_range;
		logic lo_lt_hi;
		logic holds;
		logic end_lt;
	} til_sts_t;

endpackage

>>> hdl/til_if.sv
// Valid/ready channel interfaces for request and response items.
interface til_in_if import til_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [TIME_W-1:0]   entry_start;
	logic [TIME_W-1:0]   entry_end;
	logic [TIME_W-1:0]   query_time;
	logic                seek_mode;

	modport source (output valid, output kind, output entry_start, output entry_end,
		output query_time, output seek_mode, input ready);
	modport sink (input valid, input kind, input entry_start, input entry_end,
		input query_time, input seek_mode, output ready);
endinterface

interface til_out_if import til_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 found;
	logic [OUT_IDX_W-1:0] entry_index;

	modport source (output valid, output found, output entry_index, input ready);
	modport sink (input valid, input found, input entry_index, output ready);
endinterface

>>> hdl/til_ram.sv
// Generic single-write, single-read RAM with registered read data.
module til_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/til_datapath.sv
// Table storage, entry count, search pointers and result register.
module til_datapath import til_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  til_cmd_t             cmd,
	output til_sts_t             sts,
	input  logic [TIME_W-1:0]    entry_start,
	input  logic [TIME_W-1:0]    entry_end,
	input  logic [TIME_W-1:0]    query_time,
	output logic                 found,
	output logic [OUT_IDX_W-1:0] entry_index
);

	logic [CNT_W-1:0]     count_q;
	logic [REM_W-1:0]     rem_q;
	logic [CNT_W-1:0]     ptr_q;
	logic [IDX_W-1:0]     lo_q;
	logic [IDX_W-1:0]     hi_q;
	logic [IDX_W-1:0]     addr_q;
	logic [TIME_W-1:0]    time_q;
	logic                 found_q;
	logic [OUT_IDX_W-1:0] idx_q;

	logic                 full;
	logic                 wr_en;
	logic [IDX_W:0]       mid_sum;
	logic [IDX_W-1:0]     mid;
	logic [CNT_W-1:0]     count_m1;
	logic [IDX_W-1:0]     last_idx;
	logic [IDX_W-1:0]     rd_addr;
	logic [2*TIME_W-1:0]  rd_data;
	logic [TIME_W-1:0]    rd_start;
	logic [TIME_W-1:0]    rd_end;

	assign full     = (count_q == CNT_W'(MAX_ENTRIES));
	assign wr_en    = cmd.load && !full;
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[IDX_W:1];
	assign count_m1 = count_q - CNT_W'(1);
	assign last_idx = count_m1[IDX_W-1:0];

	always_comb begin
		unique case (cmd.rd_sel)
			ADDR_PTR:   rd_addr = ptr_q[IDX_W-1:0];
			ADDR_MID:   rd_addr = mid;
			ADDR_FIRST: rd_addr = '0;
			ADDR_LAST:  rd_addr = last_idx;
		endcase
	end

	til_ram #(
		.WIDTH(2 * TIME_W),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[IDX_W-1:0]),
		.wdata({entry_start, entry_end}),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign rd_start = rd_data[2*TIME_W-1:TIME_W];
	assign rd_end   = rd_data[TIME_W-1:0];

	assign sts.cnt_zero     = (count_q == '0);
	assign sts.ptr_in_range = (ptr_q < count_q);
	assign sts.lo_lt_hi     = (lo_q < hi_q);
	assign sts.holds        = (rd_start <= time_q) && (rd_end >= time_q);
	assign sts.end_lt       = (rd_end < time_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rem_q   <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
				rem_q   <= '0;
			end else if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.res_write) begin
				if (cmd.res_found) begin
					rem_q <= REM_W'(addr_q);
				end else if (cmd.rem_zero) begin
					rem_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_query) begin
			time_q <= query_time;
			ptr_q  <= CNT_W'(rem_q);
			lo_q   <= '0;
			hi_q   <= last_idx;
		end
		if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + CNT_W'(1);
		end
		if (cmd.bs_step) begin
			if (sts.end_lt) begin
				lo_q <= addr_q + IDX_W'(1);
			end else begin
				hi_q <= addr_q;
			end
		end
		if (cmd.rd_en) begin
			addr_q <= rd_addr;
		end
		if (cmd.res_write) begin
			found_q <= cmd.res_found;
			idx_q   <= cmd.res_found ? OUT_IDX_W'(addr_q) : '0;
		end
	end

	assign found       = found_q;
	assign entry_index = idx_q;

endmodule

>>> hdl/til_ctrl.sv
// Controller state machine that sequences loads, forward scans and binary searches.
module til_ctrl import til_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [KIND_W-1:0] req_kind,
	input  logic              req_seek,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output til_cmd_t          cmd,
	input  til_sts_t          sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_CHK,
		S_BS,
		S_BS_CHK,
		S_FIRST_CHK,
		S_LAST_CHK,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_found_q;
	logic   done_found_d;
	logic   done_rem_zero_q;
	logic   done_rem_zero_d;
	logic   rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd             = '0;
		state_d         = state_q;
		done_found_d    = done_found_q;
		done_rem_zero_d = done_rem_zero_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					unique case (req_kind)
						KIND_LOAD:  cmd.load = 1'b1;
						KIND_CLEAR: cmd.clear = 1'b1;
						KIND_QUERY: begin
							cmd.cap_query = 1'b1;
							if (sts.cnt_zero) begin
								done_found_d    = 1'b0;
								done_rem_zero_d = 1'b0;
								state_d         = S_DONE;
							end else if (req_seek) begin
								state_d = S_BS;
							end else begin
								state_d = S_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				if (sts.ptr_in_range) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = ADDR_PTR;
					state_d    = S_SCAN_CHK;
				end else begin
					done_found_d    = 1'b0;
					done_rem_zero_d = 1'b0;
					state_d         = S_DONE;
				end
			end
			S_SCAN_CHK: begin
				if (sts.holds) begin
					done_found_d    = 1'b1;
					done_rem_zero_d = 1'b0;
					state_d         = S_DONE;
				end else begin
					cmd.ptr_inc = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_BS: begin
				cmd.rd_en = 1'b1;
				if (sts.lo_lt_hi) begin
					cmd.rd_sel = ADDR_MID;
					state_d    = S_BS_CHK;
				end else begin
					cmd.rd_sel = ADDR_FIRST;
					state_d    = S_FIRST_CHK;
				end
			end
			S_BS_CHK: begin
				if (sts.holds) begin
					done_found_d    = 1'b1;
					done_rem_zero_d = 1'b0;
					state_d         = S_DONE;
				end else begin
					cmd.bs_step = 1'b1;
					state_d     = S_BS;
				end
			end
			S_FIRST_CHK: begin
				if (sts.holds) begin
					done_found_d    = 1'b1;
					done_rem_zero_d = 1'b0;
					state_d         = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = ADDR_LAST;
					state_d    = S_LAST_CHK;
				end
			end
			S_LAST_CHK: begin
				done_found_d    = sts.holds;
				done_rem_zero_d = !sts.holds;
				state_d         = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.res_write = 1'b1;
					cmd.res_found = done_found_q;
					cmd.rem_zero  = done_rem_zero_q;
					state_d       = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			done_found_q    <= 1'b0;
			done_rem_zero_q <= 1'b0;
			rsp_valid_q     <= 1'b0;
		end else begin
			state_q         <= state_d;
			done_found_q    <= done_found_d;
			done_rem_zero_q <= done_rem_zero_d;
			if (cmd.res_write) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	// A result is written only into a free or draining output register.
	a_res_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_write |-> (!rsp_valid_q || rsp_ready))
		else $error("result written over a pending item");

	// A query keeps the input closed on the following cycle.
	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_kind == KIND_QUERY) |=> !req_ready)
		else $error("input reopened right after a query");

	// Every check state follows a table read.
	a_check_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_CHK || state_q == S_BS_CHK || state_q == S_FIRST_CHK ||
		 state_q == S_LAST_CHK) |-> $past(cmd.rd_en))
		else $error("entry checked without a read");

	// The response only appears after a result write.
	a_valid_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(cmd.res_write))
		else $error("response raised without a result");
`endif

endmodule

>>> hdl/timed_interval_lookup.sv
// Top level of the timed interval lookup block: controller, datapath and channels.
//
// The block holds a table of time intervals (start, end, both inclusive) in one RAM.
// Items arrive on the req channel (valid/ready). A load item appends an entry unless the
// table is full, a clear item empties the table and resets the remembered index, and a
// query item looks up query_time. Load, clear and unused kinds give no response and
// leave the controller idle. Every query gives exactly one item on the rsp channel with
// found and entry_index (zero when nothing matches).
// Without seek_mode, entries are read one by one from the remembered index; each entry
// is read from the RAM and then compared. With seek_mode, a binary search on end times
// runs; if it finds nothing, the first entry and then the last entry are checked.
// One item is worked on at a time; req.ready is high only while the controller is idle.
// A finished response waits in an output register, so the next item is accepted while
// rsp is stalled; a later query then holds in its final state until that register frees.
// Reset clears the entry count, the remembered index and the response valid. The table
// contents are not cleared; entries beyond the count are never read.
module timed_interval_lookup import til_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	til_in_if.sink    req,
	til_out_if.source rsp
);

	til_cmd_t cmd;
	til_sts_t sts;

	// Sequencing of loads, scans and searches, and the handshakes of both channels.
	til_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_kind (req.kind),
		.req_seek (req.seek_mode),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Table RAM, entry count, scan and search pointers, and the response payload.
	til_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.entry_start(req.entry_start),
		.entry_end  (req.entry_end),
		.query_time (req.query_time),
		.found      (rsp.found),
		.entry_index(rsp.entry_index)
	);

endmodule

>>> dv/timed_interval_lookup_test.sv
// Self-checking testbench of the timed interval lookup block.
module timed_interval_lookup_test;
	import til_pkg::*;

	// The fourth kind code has no meaning and must be dropped without a response.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// A receiver hold-off long enough for the block to fill up and stall its input.
	localparam int unsigned LONG_HOLD_CYCLES = 300;
	// The drain wait leaves room for a full-table forward scan, plus stalls.
	localparam int unsigned DRAIN_LIMIT = 20000;
	// Quiet cycles after the last response, to catch anything the block still sends.
	localparam int unsigned SETTLE_CYCLES = 64;

	typedef struct packed {
		logic                 found;
		logic [OUT_IDX_W-1:0] entry_index;
	} lookup_result_t;

	logic clk = 1'b0;
	logic arst_n;

	til_in_if  req_ch ();
	til_out_if rsp_ch ();

	timed_interval_lookup dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Own copy of the interval table, the entry count and the scan start.
	logic [TIME_W-1:0] tbl_start [MAX_ENTRIES];
	logic [TIME_W-1:0] tbl_end [MAX_ENTRIES];
	logic [CNT_W-1:0]  n_entries = '0;
	logic [REM_W-1:0]  scan_from = '0;

	// Responses that queries have earned and that have not come out yet, oldest first.
	lookup_result_t expected_hits [$];

	int unsigned mismatches = 0;
	int unsigned items_sent = 0;

	// Traffic shaping knobs, switched by the tests.
	bit sender_idles    = 1'b0;
	bit receiver_stalls = 1'b0;
	bit hold_request    = 1'b0;

	// Both interval bounds are inclusive.
	function automatic bit entry_holds(int unsigned j, logic [TIME_W-1:0] t);
		return tbl_start[j] <= t && tbl_end[j] >= t;
	endfunction

	// Updates the table copy for one accepted item and, for a query, records the
	// response the block owes. A seek runs a binary search on end times and then
	// checks the first and last entries, just as the block does; a forward scan
	// starts at the remembered index and stops at the first entry that holds the time.
	function automatic void predict_item(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] s,
			logic [TIME_W-1:0] e, logic [TIME_W-1:0] t, logic seek);
		lookup_result_t r;
		int unsigned    j;
		int unsigned    lo;
		int unsigned    hi;
		int unsigned    mid;
		bit             done;

		r = '0;
		done = 1'b0;
		case (kind)
			KIND_LOAD: begin
				// A load into a full table is dropped.
				if (n_entries < MAX_ENTRIES) begin
					tbl_start[n_entries] = s;
					tbl_end[n_entries] = e;
					n_entries = n_entries + 1'b1;
				end
			end
			KIND_CLEAR: begin
				n_entries = '0;
				scan_from = '0;
			end
			KIND_QUERY: begin
				// An empty table reports not found and leaves the scan start alone.
				if (n_entries != 0 && !seek) begin
					for (j = scan_from; j < n_entries; j++) begin
						if (entry_holds(j, t)) begin
							r.found = 1'b1;
							r.entry_index = j[OUT_IDX_W-1:0];
							scan_from = j[REM_W-1:0];
							break;
						end
					end
				end else if (n_entries != 0) begin
					lo = 0;
					hi = n_entries - 1;
					while (lo < hi && !done) begin
						mid = lo + (hi - lo) / 2;
						if (entry_holds(mid, t)) begin
							done = 1'b1;
							j = mid;
						end else if (tbl_end[mid] < t) begin
							lo = mid + 1;
						end else begin
							hi = mid;
						end
					end
					if (!done && entry_holds(0, t)) begin
						done = 1'b1;
						j = 0;
					end
					if (!done && entry_holds(n_entries - 1, t)) begin
						done = 1'b1;
						j = n_entries - 1;
					end
					// A seek that misses still sends the next scan back to entry zero.
					if (done) begin
						r.found = 1'b1;
						r.entry_index = j[OUT_IDX_W-1:0];
						scan_from = j[REM_W-1:0];
					end else begin
						scan_from = '0;
					end
				end
				expected_hits = {expected_hits, r};
			end
			default: begin
			end
		endcase
	endfunction

	// Offers one item and waits for the handshake. The fields change only at a
	// falling edge, and acceptance is judged at the rising edge, where ready is
	// still the value the block held during the cycle.
	task automatic send_item(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] s,
			logic [TIME_W-1:0] e, logic [TIME_W-1:0] t, logic seek);
		int unsigned gap;

		if (sender_idles && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid       <= 1'b1;
		req_ch.kind        <= kind;
		req_ch.entry_start <= s;
		req_ch.entry_end   <= e;
		req_ch.query_time  <= t;
		req_ch.seek_mode   <= seek;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
		predict_item(kind, s, e, t, seek);
	endtask

	// The fields that an item kind does not use carry random values all the same.
	task automatic send_load(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e);
		send_item(KIND_LOAD, s, e, $urandom(), 1'($urandom_range(0, 1)));
	endtask

	task automatic send_query(logic [TIME_W-1:0] t, logic seek);
		send_item(KIND_QUERY, $urandom(), $urandom(), t, seek);
	endtask

	task automatic send_other(logic [KIND_W-1:0] kind);
		send_item(kind, $urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)));
	endtask

	// Appends count intervals in ascending, non-overlapping order, which is the shape
	// the binary search relies on. Each gap and each length is at most max_step.
	task automatic load_sorted(int unsigned count, int unsigned max_step);
		longint unsigned span;
		longint unsigned next_start;
		longint unsigned s;
		longint unsigned e;

		span = longint'(count) * 2 * max_step;
		if (span < 64'h1_0000_0000)
			next_start = $urandom_range(0, int'(64'hFFFF_FFFF - span));
		else
			next_start = 0;
		repeat (count) begin
			s = next_start + $urandom_range(0, max_step);
			e = s + $urandom_range(0, max_step);
			// Past the top of the time range the intervals pile up at the last value.
			if (e > 64'hFFFF_FFFF) begin
				e = 64'hFFFF_FFFF;
				if (s > e)
					s = e;
			end
			send_load(s[TIME_W-1:0], e[TIME_W-1:0]);
			next_start = e + 1;
		end
	endtask

	// Mostly times that land in, on the edge of, or just beside a loaded interval.
	function automatic logic [TIME_W-1:0] pick_query_time();
		int unsigned j;

		if (n_entries == 0 || $urandom_range(0, 4) == 0)
			return $urandom();
		j = $urandom_range(0, n_entries - 1);
		case ($urandom_range(0, 5))
			0: return tbl_start[j];
			1: return tbl_end[j];
			2: return tbl_start[j] - 1'b1;
			3: return tbl_end[j] + 1'b1;
			default: return $urandom_range(tbl_end[j], tbl_start[j]);
		endcase
	endfunction

	// Drops valid and waits until every owed response has come out, then lets the
	// block settle. Running into the limit counts as a failure.
	task automatic wait_for_results();
		int unsigned waited;

		@(negedge clk);
		req_ch.valid <= 1'b0;
		waited = 0;
		while (expected_hits.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_hits.size() != 0) begin
			$error("%0d responses never arrived", expected_hits.size());
			mismatches++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Hand-picked items: the empty table, the ignored kind, both search modes at the
	// edges of the time range, a scan that starts past the entry it would need,
	// a seek miss that rewinds the scan, an inverted interval and the table clear.
	task automatic test_directed();
		sender_idles = 1'b1;
		receiver_stalls = 1'b1;
		send_query(32'h1234_5678, 1'b0);
		send_query(32'h0000_0000, 1'b1);
		send_other(KIND_UNUSED);
		send_load(32'h0000_0000, 32'h0000_0000);
		send_load(32'd10, 32'd20);
		send_load(32'd30, 32'd40);
		send_load(32'hFFFF_FFF0, 32'hFFFF_FFFF);
		send_query(32'd0, 1'b0);
		send_query(32'd15, 1'b0);
		send_query(32'd5, 1'b0);
		send_query(32'd0, 1'b0);
		send_query(32'hFFFF_FFFF, 1'b0);
		send_query(32'd35, 1'b0);
		send_query(32'd35, 1'b1);
		send_query(32'd25, 1'b1);
		send_query(32'd40, 1'b0);
		send_query(32'd0, 1'b1);
		send_other(KIND_CLEAR);
		send_query(32'd10, 1'b1);
		send_query(32'd10, 1'b0);
		// The inverted interval can never hold a time; the wide one behind it is
		// found only by the last-entry check after the binary search.
		send_load(32'd100, 32'd50);
		send_load(32'h0000_0000, 32'hFFFF_FFFF);
		send_query(32'd75, 1'b1);
		send_query(32'd75, 1'b0);
		send_other(KIND_CLEAR);
	endtask

	// Fills the table to the last entry, offers two loads that must be dropped, and
	// queries across the whole range, including long forward scans.
	task automatic test_full_table();
		sender_idles = 1'b1;
		receiver_stalls = 1'b1;
		load_sorted(MAX_ENTRIES + 2, 1 << 20);
		send_query(tbl_start[0], 1'b1);
		send_query(tbl_end[MAX_ENTRIES - 1], 1'b1);
		send_query(tbl_end[MAX_ENTRIES - 1], 1'b0);
		send_query(tbl_start[MAX_ENTRIES / 2], 1'b1);
		repeat (40)
			send_query(pick_query_time(), 1'($urandom_range(0, 1)));
		send_other(KIND_CLEAR);
	endtask

	// The receiver holds off for a long stretch while queries keep coming, so the
	// response register and the controller both fill and the input stalls. Then the
	// sender waits for every response before going on.
	task automatic test_backpressure();
		sender_idles = 1'b0;
		receiver_stalls = 1'b0;
		load_sorted(6, 50);
		hold_request = 1'b1;
		repeat (10)
			send_query(pick_query_time(), 1'($urandom_range(0, 1)));
		wait_for_results();
		repeat (4)
			send_query(pick_query_time(), 1'($urandom_range(0, 1)));
		send_other(KIND_CLEAR);
	endtask

	// Phases of loads followed by queries. Most phases load sorted intervals with
	// random content; the rest send noise of every kind, unsorted and overlapping
	// intervals included. Idling is switched per phase so some phases run clean.
	task automatic test_random_phases(int unsigned item_goal);
		int unsigned first_item;
		int unsigned n_load;
		int unsigned max_step;

		first_item = items_sent;
		while (items_sent - first_item < item_goal) begin
			sender_idles = $urandom_range(0, 3) != 0;
			receiver_stalls = $urandom_range(0, 3) != 0;
			if (n_entries > 200 || $urandom_range(0, 3) != 0)
				send_other(KIND_CLEAR);
			n_load = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48)
				: $urandom_range(0, 16);
			case ($urandom_range(0, 2))
				0: max_step = 3;
				1: max_step = 200;
				default: max_step = 1 << 24;
			endcase
			if ($urandom_range(0, 5) != 0) begin
				load_sorted(n_load, max_step);
			end else begin
				repeat (n_load)
					send_item(KIND_W'($urandom_range(0, 3)), $urandom(), $urandom(),
						$urandom(), 1'($urandom_range(0, 1)));
			end
			repeat ($urandom_range(4, 16)) begin
				if ($urandom_range(0, 15) == 0)
					send_other(KIND_UNUSED);
				else
					send_query(pick_query_time(), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// The closing stretch runs with no idling on either side.
	task automatic test_steady_tail();
		sender_idles = 1'b0;
		receiver_stalls = 1'b0;
		send_other(KIND_CLEAR);
		load_sorted(12, 1000);
		repeat (50)
			send_query(pick_query_time(), 1'($urandom_range(0, 1)));
	endtask

	// Response side: ready is low in random bursts, or for one long stretch when a
	// test asks for it, and high otherwise.
	initial begin : rsp_driver
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
			end else if (receiver_stalls && $urandom_range(0, 9) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14) - 1) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Every accepted response is matched against the oldest owed one.
	always @(posedge clk) begin : rsp_check
		lookup_result_t want;

		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_hits.size() == 0) begin
				$error("response with none owed: found %0b entry_index %0d",
					rsp_ch.found, rsp_ch.entry_index);
				mismatches++;
			end else begin
				want = expected_hits.pop_front();
				if (rsp_ch.found !== want.found) begin
					$error("found: expected %0b, actual %0b", want.found, rsp_ch.found);
					mismatches++;
				end
				if (rsp_ch.entry_index !== want.entry_index) begin
					$error("entry_index: expected %0d, actual %0d",
						want.entry_index, rsp_ch.entry_index);
					mismatches++;
				end
			end
		end
	end

	initial begin : run_limit
		#60000000;
		$display("timed_interval_lookup: mismatch");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_LOAD;
		req_ch.entry_start = '0;
		req_ch.entry_end = '0;
		req_ch.query_time = '0;
		req_ch.seek_mode = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_table();
		test_backpressure();
		test_random_phases(220);
		test_steady_tail();
		wait_for_results();

		if (mismatches == 0) begin
			$display("timed_interval_lookup: match");
		end else begin
			$display("timed_interval_lookup: mismatch");
		end
		$finish;
	end

endmodule
